FILE: rtl/lant_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lant_pkg
// Shared constants and types of the multi-color ant step core: default
// geometry, field widths, register indexes, heading codes and the control
// bundle that the step unit returns to the sequencer.
// ---------------------------------------------------------------------------
package lant_pkg;

	localparam int GRID_W_DEF     = 64;
	localparam int GRID_H_DEF     = 64;
	localparam int MAX_COLORS_DEF = 16;

	localparam int COLOR_W = 4;
	localparam int NCOL_W  = 5;
	localparam int RULE_W  = 32;
	localparam int CNT_W   = 32;
	localparam int POS_O_W = 6;

	localparam logic REG_NUM_COLORS = 1'b0;
	localparam logic REG_TURN_RULE  = 1'b1;

	localparam logic [1:0] HD_UP    = 2'd0;
	localparam logic [1:0] HD_RIGHT = 2'd1;
	localparam logic [1:0] HD_DOWN  = 2'd2;
	localparam logic [1:0] HD_LEFT  = 2'd3;

	typedef struct packed {
		logic [1:0]         heading;
		logic [COLOR_W-1:0] color_next;
		logic               leaves;
	} step_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/multicolor_langton_ant_step_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// multicolor_langton_ant_step_core
// Multi-color turmite on a cell grid: step the ant or read back one cell.
// ---------------------------------------------------------------------------
//  channel  | dir | beat content
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tuser: func; tdata: cell_x, cell_y
//  m_*      | out | tdata: ant_x, ant_y, heading, cell_color, move_count, halted
//  cfg_*    | in  | register write: index 0 num_colors, 1 turn_rule
//
//  Per beat, accept issues the cell read and the execute cycle turns,
//  writes the cell back and loads the result register.
//  The registered read of the cell RAM sets this split.
//  After reset a clearing pass writes zero to every cell of the grid;
//  s_tready stays low meanwhile, cfg writes are taken at any time.
//  A held result adds stall cycles to the execute cycle of the next beat.
// ---------------------------------------------------------------------------
module multicolor_langton_ant_step_core
	import lant_pkg::*;
#(
	parameter int GRID_W     = GRID_W_DEF,
	parameter int GRID_H     = GRID_H_DEF,
	parameter int MAX_COLORS = MAX_COLORS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // cell_x[5:0], cell_y[11:6], zero[15:12]
	input  wire         s_tuser,   // func[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // ant_x[5:0], ant_y[11:6], heading[13:12],
	                               // cell_color[17:14], move_count[49:18],
	                               // halted[50], zero[55:51]
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_wdata
);

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int DEPTH = GRID_W * GRID_H;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [NCOL_W-1:0]   num_colors_q;
	logic [RULE_W-1:0]   turn_rule_q;
	logic [XW-1:0]       pos_x_q;
	logic [YW-1:0]       pos_y_q;
	logic [1:0]          heading_q;
	logic [CNT_W-1:0]    count_q;
	logic                halted_q;
	logic                func_q;
	logic                rd_ok_q;
	logic                out_valid_q;
	logic [55:0]         out_data_q;

	logic [5:0]          in_x;
	logic [5:0]          in_y;
	logic                accept;
	logic                out_free;
	logic                fire;
	logic                do_step;
	logic                rd_ok;
	logic [AW-1:0]       ant_addr;
	logic [AW-1:0]       cell_addr;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [COLOR_W-1:0]  ram_wdata;
	logic [COLOR_W-1:0]  ram_rdata;
	logic [XW-1:0]       next_x;
	logic [YW-1:0]       next_y;
	step_ctl_t           step_ctl;
	logic [COLOR_W-1:0]  res_color;
	logic [CNT_W-1:0]    res_count;
	logic [XW-1:0]       res_x;
	logic [YW-1:0]       res_y;
	logic [1:0]          res_hd;
	logic                res_halted;

	assign in_x      = s_tdata[5:0];
	assign in_y      = s_tdata[11:6];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign fire      = (state_q == ST_RUN) && out_free;
	assign do_step   = fire && !func_q && !halted_q;
	assign rd_ok     = (32'(in_x) < GRID_W) && (32'(in_y) < GRID_H);
	assign ant_addr  = AW'(32'(pos_y_q) * GRID_W + 32'(pos_x_q));
	assign cell_addr = AW'(32'(in_y) * GRID_W + 32'(in_x));

	assign ram_we    = (state_q == ST_CLEAR) || do_step;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : ant_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : step_ctl.color_next;

	lant_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (s_tuser ? cell_addr : ant_addr),
		.rdata (ram_rdata)
	);

	lant_step #(
		.GRID_W     (GRID_W),
		.GRID_H     (GRID_H),
		.MAX_COLORS (MAX_COLORS)
	) u_step (
		.color      (ram_rdata),
		.heading    (heading_q),
		.pos_x      (pos_x_q),
		.pos_y      (pos_y_q),
		.num_colors (num_colors_q),
		.turn_rule  (turn_rule_q),
		.next_x     (next_x),
		.next_y     (next_y),
		.ctl        (step_ctl)
	);

	always_comb begin
		res_x      = pos_x_q;
		res_y      = pos_y_q;
		res_hd     = heading_q;
		res_count  = count_q;
		res_halted = halted_q;
		res_color  = '0;
		if (func_q) begin
			res_color = rd_ok_q ? ram_rdata : '0;
		end else if (!halted_q) begin
			res_x      = next_x;
			res_y      = next_y;
			res_hd     = step_ctl.heading;
			res_color  = step_ctl.color_next;
			res_count  = (count_q == '1) ? count_q : count_q + CNT_W'(1);
			res_halted = step_ctl.leaves;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			num_colors_q <= NCOL_W'(2);
			turn_rule_q  <= RULE_W'(13);
			pos_x_q      <= XW'(GRID_W / 2);
			pos_y_q      <= YW'(GRID_H / 2);
			heading_q    <= HD_UP;
			count_q      <= '0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_COLORS: num_colors_q <= cfg_wdata[NCOL_W-1:0];
					REG_TURN_RULE:  turn_rule_q  <= cfg_wdata;
				endcase
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (fire) begin
				pos_x_q     <= res_x;
				pos_y_q     <= res_y;
				heading_q   <= res_hd;
				count_q     <= res_count;
				halted_q    <= res_halted;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= s_tuser;
			rd_ok_q <= rd_ok;
		end
		if (fire) begin
			out_data_q <= {5'b0, res_halted, res_count, res_color, res_hd,
			               POS_O_W'(res_y), POS_O_W'(res_x)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

FILE: rtl/lant_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lant_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ---------------------------------------------------------------------------
module lant_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lant_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lant_step
// Step unit: turn by the rule of the current cell color, advance the color
// cyclically and move one cell in the new heading, flagging a grid exit.
// ---------------------------------------------------------------------------
module lant_step
	import lant_pkg::*;
#(
	parameter int GRID_W     = GRID_W_DEF,
	parameter int GRID_H     = GRID_H_DEF,
	parameter int MAX_COLORS = MAX_COLORS_DEF
) (
	input  wire [COLOR_W-1:0]        color,
	input  wire [1:0]                heading,
	input  wire [$clog2(GRID_W)-1:0] pos_x,
	input  wire [$clog2(GRID_H)-1:0] pos_y,
	input  wire [NCOL_W-1:0]         num_colors,
	input  wire [RULE_W-1:0]         turn_rule,
	output logic [$clog2(GRID_W)-1:0] next_x,
	output logic [$clog2(GRID_H)-1:0] next_y,
	output step_ctl_t                 ctl
);

	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);

	logic [NCOL_W-1:0] eff_colors;
	logic [NCOL_W-1:0] color_inc;
	logic [1:0]        turn;
	logic [1:0]        new_hd;

	always_comb begin
		if (num_colors < NCOL_W'(2)) begin
			eff_colors = NCOL_W'(2);
		end else if (num_colors > NCOL_W'(MAX_COLORS)) begin
			eff_colors = NCOL_W'(MAX_COLORS);
		end else begin
			eff_colors = num_colors;
		end
		color_inc = NCOL_W'(color) + NCOL_W'(1);
		turn      = 2'(turn_rule >> {color, 1'b0});
		new_hd    = heading + turn;

		ctl.heading    = new_hd;
		ctl.color_next = (color_inc >= eff_colors) ? '0 : COLOR_W'(color_inc);
		ctl.leaves     = 1'b0;
		next_x         = pos_x;
		next_y         = pos_y;

		unique case (new_hd)
			HD_UP: begin
				if (pos_y == '0) ctl.leaves = 1'b1;
				else next_y = pos_y - YW'(1);
			end
			HD_RIGHT: begin
				if (pos_x == XW'(GRID_W - 1)) ctl.leaves = 1'b1;
				else next_x = pos_x + XW'(1);
			end
			HD_DOWN: begin
				if (pos_y == YW'(GRID_H - 1)) ctl.leaves = 1'b1;
				else next_y = pos_y + YW'(1);
			end
			HD_LEFT: begin
				if (pos_x == '0) ctl.leaves = 1'b1;
				else next_x = pos_x - XW'(1);
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/lant_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lant_checker
// Port-level checks of the ant step core: result hold under stall, busy
// window after an accepted beat, and a valid result following it.
// ---------------------------------------------------------------------------
module lant_checker (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	input wire s_tready,
	input wire m_tvalid,
	input wire m_tready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("beat accepted during execute cycle");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("no result after accepted beat");

endmodule

bind multicolor_langton_ant_step_core lant_checker u_lant_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
`default_nettype wire

FILE: sim/multicolor_langton_ant_step_core_test.sv
// ---------------------------------------------------------------------------
// multicolor_langton_ant_step_core_test
// Self-checking bench for the turmite step core. A queue-fed driver and a
// monitor run the stream ports with random gaps and stalls. Each accepted
// input beat runs through a local model of the grid, ant and counters. The
// monitor checks every result beat field by field against the oldest
// prediction. Rule sets change between phases while the core is idle: the
// ant gets free rules only for as many steps as it is from the edge, or a
// rule that keeps it turning near its cell. The last phase drives it off
// the grid and keeps stepping it.
// ---------------------------------------------------------------------------
module multicolor_langton_ant_step_core_test;
	import lant_pkg::*;

	localparam logic        FN_STEP    = 1'b0;
	localparam logic        FN_READ    = 1'b1;
	localparam logic [31:0] ALL_RIGHT  = 32'h5555_5555;
	localparam logic [31:0] ALL_BACK   = 32'hAAAA_AAAA;
	localparam logic [31:0] ALL_LEFT   = 32'hFFFF_FFFF;
	localparam logic [31:0] ALL_AHEAD  = 32'h0000_0000;
	localparam int          CELLS      = GRID_W_DEF * GRID_H_DEF;
	localparam int          RANDOM_CNT = 1200;
	localparam int          IDLE_LIMIT = 24000;

	typedef struct packed {
		logic       func;
		logic [5:0] cy;
		logic [5:0] cx;
	} ant_cmd_t;

	typedef struct packed {
		logic        halted;
		logic [31:0] moves;
		logic [3:0]  color;
		logic [1:0]  hd;
		logic [5:0]  y;
		logic [5:0]  x;
	} ant_res_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_NUM_COLORS;
	logic [31:0] cfg_wdata = '0;

	// model state
	logic [3:0]  tiles [CELLS];
	int          ax = GRID_W_DEF / 2;
	int          ay = GRID_H_DEF / 2;
	logic [1:0]  dir = HD_UP;
	logic [31:0] moves = '0;
	logic        gone = 1'b0;
	logic [4:0]  cfg_ncol = 5'd2;
	logic [31:0] cfg_rule = 32'd13;

	ant_cmd_t    ant_cmds [$];
	ant_res_t    ant_due [$];
	ant_cmd_t    next_cmd;
	ant_res_t    got;
	ant_res_t    want;
	int          pace = 2;
	int          src_gap = 0;
	int          sink_gap = 0;
	int          sink_draw = 0;
	int          idle_cycles = 0;
	int          errors = 0;

	multicolor_langton_ant_step_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic ant_res_t turmite_apply(ant_cmd_t cmd);
		ant_res_t res;
		int       ncol;
		int       c;
		int       idx;
		res.color = '0;
		if (cmd.func == FN_READ) begin
			res.color = tiles[int'(cmd.cy) * GRID_W_DEF + int'(cmd.cx)];
		end else if (!gone) begin
			idx = ay * GRID_W_DEF + ax;
			c = int'(tiles[idx]);
			dir = dir + cfg_rule[2 * c +: 2];
			ncol = int'(cfg_ncol);
			if (ncol < 2)
				ncol = 2;
			if (ncol > MAX_COLORS_DEF)
				ncol = MAX_COLORS_DEF;
			tiles[idx] = (c + 1 >= ncol) ? 4'd0 : 4'(c + 1);
			res.color = tiles[idx];
			if (moves != '1)
				moves = moves + 1;
			case (dir)
				HD_UP: begin
					if (ay == 0) gone = 1'b1; else ay--;
				end
				HD_RIGHT: begin
					if (ax == GRID_W_DEF - 1) gone = 1'b1; else ax++;
				end
				HD_DOWN: begin
					if (ay == GRID_H_DEF - 1) gone = 1'b1; else ay++;
				end
				default: begin
					if (ax == 0) gone = 1'b1; else ax--;
				end
			endcase
		end
		res.x      = ax[5:0];
		res.y      = ay[5:0];
		res.hd     = dir;
		res.moves  = moves;
		res.halted = gone;
		return res;
	endfunction

	function automatic int edge_room();
		int d;
		d = ax;
		if (ay < d) d = ay;
		if (GRID_W_DEF - 1 - ax < d) d = GRID_W_DEF - 1 - ax;
		if (GRID_H_DEF - 1 - ay < d) d = GRID_H_DEF - 1 - ay;
		return d;
	endfunction

	function automatic int gap_draw();
		case (pace)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_beat(input ant_res_t exp_res, input ant_res_t act_res);
		if (act_res.x !== exp_res.x)
			flag($sformatf("ant_x got %0d want %0d", act_res.x, exp_res.x));
		if (act_res.y !== exp_res.y)
			flag($sformatf("ant_y got %0d want %0d", act_res.y, exp_res.y));
		if (act_res.hd !== exp_res.hd)
			flag($sformatf("heading got %0d want %0d", act_res.hd, exp_res.hd));
		if (act_res.color !== exp_res.color)
			flag($sformatf("cell_color got %0d want %0d", act_res.color, exp_res.color));
		if (act_res.moves !== exp_res.moves)
			flag($sformatf("move_count got %0d want %0d", act_res.moves, exp_res.moves));
		if (act_res.halted !== exp_res.halted)
			flag($sformatf("halted got %0b want %0b", act_res.halted, exp_res.halted));
	endtask

	task automatic push_step();
		ant_cmd_t cmd;
		cmd = '{func: FN_STEP, cy: 6'($urandom()), cx: 6'($urandom())};
		ant_cmds = {ant_cmds, cmd};
	endtask

	task automatic push_read(input logic [5:0] x, input logic [5:0] y);
		ant_cmd_t cmd;
		cmd = '{func: FN_READ, cy: y, cx: x};
		ant_cmds = {ant_cmds, cmd};
	endtask

	// read close to the ant most of the time, anywhere otherwise
	task automatic push_probe();
		if ($urandom_range(0, 3) == 0)
			push_read(6'($urandom()), 6'($urandom()));
		else
			push_read(6'(ax + int'($urandom_range(0, 8)) - 4),
			          6'(ay + int'($urandom_range(0, 8)) - 4));
	endtask

	// write both registers on back-to-back edges
	task automatic load_rule(input logic [4:0] ncol, input logic [31:0] rule);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_COLORS;
		cfg_wdata <= {27'd0, ncol};
		@(posedge clk);
		cfg_index <= REG_TURN_RULE;
		cfg_wdata <= rule;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_ncol = ncol;
		cfg_rule = rule;
		@(negedge clk);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (ant_cmds.size() != 0 || s_tvalid || ant_due.size() != 0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				ant_due = {ant_due, turmite_apply(ant_cmd_t'({s_tuser, s_tdata[11:0]}))};
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= src_gap - 1;
				end else if (ant_cmds.size() != 0) begin
					next_cmd = ant_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_cmd.func;
					s_tdata  <= {4'd0, next_cmd.cy, next_cmd.cx};
					src_gap  <= gap_draw();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else if (m_tvalid && m_tready) begin
			got = ant_res_t'(m_tdata[50:0]);
			if (ant_due.size() == 0) begin
				flag("result beat with nothing outstanding");
			end else begin
				want = ant_due.pop_front();
				check_beat(want, got);
			end
			sink_draw = gap_draw();
			sink_gap <= sink_draw;
			m_tready <= (sink_draw == 0);
		end else if (!m_tready) begin
			if (sink_gap > 1)
				sink_gap <= sink_gap - 1;
			else
				m_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stim
		int          done;
		int          d;
		int          steps;
		int          reads;
		logic [4:0]  ncol;
		logic [31:0] rule;
		for (int i = 0; i < CELLS; i++)
			tiles[i] = 4'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners and center, classic ant near the center
		push_read(6'd0, 6'd0);
		push_read(6'd63, 6'd63);
		push_read(6'd0, 6'd63);
		push_read(6'd63, 6'd0);
		push_read(6'd32, 6'd32);
		repeat (8) push_step();
		push_read(6'd32, 6'd32);
		push_read(6'd31, 6'd32);
		push_read(6'd32, 6'd31);
		settle();
		// full palette, then shrink it so high colors go stale
		load_rule(5'd16, ALL_RIGHT);
		repeat (4) push_step();
		settle();
		load_rule(5'd0, ALL_BACK);
		repeat (4) push_step();
		push_read(6'(ax), 6'(ay));
		settle();

		done = 0;
		while (done < RANDOM_CNT) begin
			d = edge_room();
			case ($urandom_range(0, 7))
				0: ncol = 5'($urandom_range(0, 1));
				1: ncol = 5'd16;
				2: ncol = 5'($urandom_range(17, 31));
				3: ncol = 5'd2;
				default: ncol = 5'($urandom_range(3, 15));
			endcase
			if (d < 3 || $urandom_range(0, 4) == 0) begin
				case ((d == 0) ? 2 : int'($urandom_range(0, 2)))
					0: rule = ALL_LEFT;
					1: rule = ALL_RIGHT;
					default: rule = ALL_BACK;
				endcase
				steps = $urandom_range(8, 40);
			end else begin
				rule = ($urandom_range(0, 4) == 0) ? 32'd13 : 32'($urandom());
				steps = $urandom_range(1, (d < 40) ? d : 40);
			end
			reads = $urandom_range(0, steps / 2 + 4);
			pace = $urandom_range(0, 3);
			load_rule(ncol, rule);
			done += steps + reads;
			while (steps + reads > 0) begin
				if (reads == 0 || (steps != 0 && $urandom_range(0, steps + reads - 1) < steps)) begin
					push_step();
					steps--;
				end else begin
					push_probe();
					reads--;
				end
			end
			settle();
		end

		// straight ahead until the ant walks off, then keep stepping
		pace = 2;
		load_rule(5'd31, ALL_AHEAD);
		for (int i = 0; i < 80; i++) begin
			push_step();
			if ($urandom_range(0, 3) == 0)
				push_probe();
		end
		push_read(6'd0, 6'd0);
		push_read(6'd63, 6'd63);
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
